>>> design/assert_macros.svh
// assertion helpers shared by the rtl files
// both expect signals named clk and arst_n in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define LCCFB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// antecedent this cycle implies consequent on the next edge
`define LCCFB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/lccfb_pkg.sv
// ----------------------------------------------------------------------------
// lccfb_pkg
// shared types and constants of the led cube crossfade buffer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lccfb_pkg;

	localparam logic [1:0] CMD_SET_PIXEL = 2'd0;
	localparam logic [1:0] CMD_LATCH     = 2'd1;
	localparam logic [1:0] CMD_DRAW      = 2'd2;

	// reciprocal of the crossfade length, scaled by 2^RECIP_SHIFT and rounded up
	localparam int unsigned RECIP_SHIFT = 24;
	localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
	localparam logic [7:0]  RESET_TICKS = 8'd16;
	localparam logic [RECIP_W-1:0] RESET_RECIP = RECIP_W'(1) << 20;

	localparam logic [7:0] CHANNEL_MASK = 8'hFF;

	typedef struct packed {
		logic [1:0]  command;
		logic [1:0]  pos_z;
		logic [1:0]  pos_x;
		logic [1:0]  pos_y;
		logic [23:0] pixel_color;
		logic [7:0]  tick;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  out_z;
		logic [1:0]  out_x;
		logic [1:0]  out_y;
		logic [23:0] blended_color;
		logic        last_update;
	} out_item_t;

	// scan slot issued to the memories, aligned with the read data
	typedef struct packed {
		logic       valid;
		logic       last;
		logic [5:0] pos;
	} scan_ctl_t;

	typedef struct packed {
		logic done;
	} blend_stat_t;

	typedef struct packed {
		logic busy;
	} recip_stat_t;

endpackage

`default_nettype wire

>>> design/led_cube_crossfade_buffer.sv
// ----------------------------------------------------------------------------
// led_cube_crossfade_buffer
// two-frame rgb888 store for a 4x4x4 led cube with linear crossfade output
// ----------------------------------------------------------------------------
// Commands are taken when start is high and busy is low. set pixel writes one
// target entry in the accepting cycle and leaves busy low. latch copies the
// target frame into the source frame, one entry per cycle through the target
// read port, holding busy while it walks the frame. draw reads both frames one
// pixel per cycle and then drains the blend pipeline with busy still high; each
// differing pixel comes out as one transfer on result with result_valid high
// for exactly one cycle, and the receiver cannot stall, so it must take every
// transfer. The final transfer of a scan has last_update set and appears just
// as busy drops. A write on the configuration port recomputes the crossfade
// reciprocal with a bit-serial divider and holds busy while it runs. After
// reset both frames are cleared by a sweep over all CUBE_PIXELS entries during
// which busy is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module led_cube_crossfade_buffer #(
	parameter int unsigned CUBE_PIXELS = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  lccfb_pkg::in_item_t       item,
	input  wire logic                 cfg_we,
	input  wire logic [7:0]           cfg_wdata,
	output lccfb_pkg::out_item_t      result,
	output logic                      result_valid
);

	import lccfb_pkg::*;

	localparam int unsigned AW   = $clog2(CUBE_PIXELS);
	// only the first 64 entries are reachable by the 2-bit coordinates
	localparam int unsigned SCAN = (CUBE_PIXELS < 64) ? CUBE_PIXELS : 64;
	localparam logic [AW-1:0] CLEAR_END = AW'(CUBE_PIXELS - 1);
	localparam logic [AW-1:0] SCAN_END  = AW'(SCAN - 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_LATCH = 3'd2;
	localparam logic [2:0] ST_DRAW  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;

	logic [2:0]    state_q;
	logic [AW-1:0] cnt_q;
	logic [7:0]    k_q, tk_q;
	logic          lat_v_s1;
	logic [AW-1:0] lat_addr_s1;
	scan_ctl_t     ctl_s1;

	logic          accept;
	logic [5:0]    set_idx;
	logic          set_we;

	logic [7:0]         ticks;
	logic [RECIP_W-1:0] recip;
	recip_stat_t        rstat;
	blend_stat_t        bstat;

	logic          tgt_we, src_we;
	logic [AW-1:0] tgt_waddr, src_waddr;
	logic [23:0]   tgt_wdata, src_wdata, tgt_rdata, src_rdata;

	logic [8:0]    tick_p1;
	logic [7:0]    k_next;

	assign busy   = (state_q != ST_IDLE) || rstat.busy;
	assign accept = start && !busy;

	// pixel (z,x,y) lives at z*16 + x*4 + y
	assign set_idx = {item.pos_z, item.pos_x, item.pos_y};
	assign set_we  = accept && (item.command == CMD_SET_PIXEL) &&
		(32'(set_idx) < CUBE_PIXELS);

	// blend weight saturates at the crossfade length
	assign tick_p1 = {1'b0, item.tick} + 9'd1;
	assign k_next  = (tick_p1 > {1'b0, ticks}) ? ticks : tick_p1[7:0];

	// target write: clear sweep or a set-pixel transfer
	assign tgt_we    = (state_q == ST_CLEAR) || set_we;
	assign tgt_waddr = (state_q == ST_CLEAR) ? cnt_q : AW'(set_idx);
	assign tgt_wdata = (state_q == ST_CLEAR) ? 24'd0 : item.pixel_color;

	// source write: clear sweep or latch copy, in the cycle after the target read
	assign src_we    = (state_q == ST_CLEAR) || lat_v_s1;
	assign src_waddr = (state_q == ST_CLEAR) ? cnt_q : lat_addr_s1;
	assign src_wdata = (state_q == ST_CLEAR) ? 24'd0 : tgt_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			cnt_q        <= '0;
			lat_v_s1     <= 1'b0;
			ctl_s1.valid <= 1'b0;
			ctl_s1.last  <= 1'b0;
			ctl_s1.pos   <= '0;
		end else begin
			lat_v_s1     <= 1'b0;
			ctl_s1.valid <= 1'b0;
			ctl_s1.last  <= 1'b0;
			ctl_s1.pos   <= 6'(cnt_q);
			case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == CLEAR_END) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept && item.command == CMD_LATCH) begin
						state_q <= ST_LATCH;
					end else if (accept && item.command == CMD_DRAW) begin
						state_q <= ST_DRAW;
					end
				end
				ST_LATCH: begin
					lat_v_s1 <= 1'b1;
					cnt_q    <= cnt_q + AW'(1);
					if (cnt_q == SCAN_END) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_DRAW: begin
					ctl_s1.valid <= 1'b1;
					ctl_s1.last  <= (cnt_q == SCAN_END);
					cnt_q        <= cnt_q + AW'(1);
					if (cnt_q == SCAN_END) begin
						cnt_q   <= '0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// wait for the scan end marker to leave the blend pipe
					if (bstat.done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		lat_addr_s1 <= cnt_q;
		if (accept && item.command == CMD_DRAW) begin
			k_q  <= k_next;
			tk_q <= ticks - k_next;
		end
	end

	lccfb_frames #(
		.DEPTH (CUBE_PIXELS),
		.AW    (AW)
	) u_frames (
		.clk       (clk),
		.tgt_we    (tgt_we),
		.tgt_waddr (tgt_waddr),
		.tgt_wdata (tgt_wdata),
		.tgt_raddr (cnt_q),
		.tgt_rdata (tgt_rdata),
		.src_we    (src_we),
		.src_waddr (src_waddr),
		.src_wdata (src_wdata),
		.src_raddr (cnt_q),
		.src_rdata (src_rdata)
	);

	lccfb_recip u_recip (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ticks     (ticks),
		.recip     (recip),
		.stat      (rstat)
	);

	lccfb_blend u_blend (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl_s1       (ctl_s1),
		.src_s1       (src_rdata),
		.dst_s1       (tgt_rdata),
		.k            (k_q),
		.tk           (tk_q),
		.recip        (recip),
		.result       (result),
		.result_valid (result_valid),
		.stat         (bstat)
	);

	// results only come out of a draw scan or its drain
	`LCCFB_ASSERT(a_result_from_draw, result_valid |-> $past(state_q == ST_DRAW || state_q == ST_DRAIN), "result outside a draw scan")
	// nothing follows the flagged last transfer of a scan
	`LCCFB_ASSERT_NEXT(a_last_ends_scan, result_valid && result.last_update, !result_valid, "result after last_update")
	// the clear sweep runs once, straight out of reset
	`LCCFB_ASSERT(a_clear_once, state_q == ST_CLEAR |-> $past(state_q) == ST_CLEAR, "clear sweep re-entered")

endmodule

`default_nettype wire

>>> design/lccfb_frames.sv
// ----------------------------------------------------------------------------
// lccfb_frames
// source and target frame memories, one write and one registered read each
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lccfb_frames #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  wire logic          clk,
	input  wire logic          tgt_we,
	input  wire logic [AW-1:0] tgt_waddr,
	input  wire logic [23:0]   tgt_wdata,
	input  wire logic [AW-1:0] tgt_raddr,
	output logic      [23:0]   tgt_rdata,
	input  wire logic          src_we,
	input  wire logic [AW-1:0] src_waddr,
	input  wire logic [23:0]   src_wdata,
	input  wire logic [AW-1:0] src_raddr,
	output logic      [23:0]   src_rdata
);

	logic [23:0] tgt_mem [DEPTH];
	logic [23:0] src_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (tgt_we) begin
			tgt_mem[tgt_waddr] <= tgt_wdata;
		end
		tgt_rdata <= tgt_mem[tgt_raddr];
	end

	always_ff @(posedge clk) begin
		if (src_we) begin
			src_mem[src_waddr] <= src_wdata;
		end
		src_rdata <= src_mem[src_raddr];
	end

endmodule

`default_nettype wire

>>> design/lccfb_recip.sv
// ----------------------------------------------------------------------------
// lccfb_recip
// crossfade length register and its scaled reciprocal, one quotient bit a cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lccfb_recip (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [7:0]                    cfg_wdata,
	output logic [7:0]                         ticks,
	output logic [lccfb_pkg::RECIP_W-1:0]      recip,
	output lccfb_pkg::recip_stat_t             stat
);

	import lccfb_pkg::*;

	localparam logic [4:0] STEPS = 5'(RECIP_W);

	logic [7:0]         ticks_q;
	logic [RECIP_W-1:0] recip_q;
	logic [RECIP_W-1:0] quo_q;
	logic [7:0]         rem_q;
	logic [4:0]         cnt_q;
	logic               run_q;

	logic [7:0]         t_eff;
	logic [8:0]         trial;
	logic               qbit;
	logic [7:0]         rem_next;
	logic [RECIP_W-1:0] quo_next;

	// zero length behaves as one
	assign t_eff = (cfg_wdata == 8'd0) ? 8'd1 : cfg_wdata;

	// restoring step on 2^RECIP_SHIFT, only the top dividend bit is set
	always_comb begin
		trial    = {rem_q, (cnt_q == STEPS)};
		qbit     = (trial >= {1'b0, ticks_q});
		rem_next = qbit ? 8'(trial - {1'b0, ticks_q}) : trial[7:0];
		quo_next = {quo_q[RECIP_W-2:0], qbit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= RESET_TICKS;
			recip_q <= RESET_RECIP;
			run_q   <= 1'b0;
			cnt_q   <= '0;
		end else if (cfg_we) begin
			ticks_q <= t_eff;
			run_q   <= 1'b1;
			cnt_q   <= STEPS;
		end else if (run_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) begin
				run_q   <= 1'b0;
				recip_q <= quo_next + RECIP_W'(rem_next != 8'd0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cfg_we) begin
			quo_q <= '0;
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= quo_next;
			rem_q <= rem_next;
		end
	end

	assign ticks     = ticks_q;
	assign recip     = recip_q;
	assign stat.busy = run_q;

endmodule

`default_nettype wire

>>> design/lccfb_blend.sv
// ----------------------------------------------------------------------------
// lccfb_blend
// compare, weight, reciprocal multiply and last-result lookahead per pixel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lccfb_blend (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  lccfb_pkg::scan_ctl_t               ctl_s1,
	input  wire logic [23:0]                   src_s1,
	input  wire logic [23:0]                   dst_s1,
	input  wire logic [7:0]                    k,
	input  wire logic [7:0]                    tk,
	input  wire logic [lccfb_pkg::RECIP_W-1:0] recip,
	output lccfb_pkg::out_item_t               result,
	output logic                               result_valid,
	output lccfb_pkg::blend_stat_t             stat
);

	import lccfb_pkg::*;

	localparam int unsigned PW = 16 + RECIP_W;

	logic             v_s2, end_s2, v_s3, end_s3, v_s4, end_s4, end_s5;
	logic [5:0]       pos_s2, pos_s3, pos_s4;
	logic [2:0][15:0] ps_s2, pd_s2, sum_s3;
	logic [2:0][7:0]  q_s4;
	logic [2:0][PW-1:0] prod;

	logic             held_v_q;
	logic [5:0]       held_pos_q;
	logic [23:0]      held_col_q;
	logic             res_v_q;
	out_item_t        res_q;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			prod[c] = PW'(sum_s3[c]) * PW'(recip);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2     <= 1'b0;
			end_s2   <= 1'b0;
			v_s3     <= 1'b0;
			end_s3   <= 1'b0;
			v_s4     <= 1'b0;
			end_s4   <= 1'b0;
			end_s5   <= 1'b0;
			held_v_q <= 1'b0;
			res_v_q  <= 1'b0;
		end else begin
			v_s2   <= ctl_s1.valid && (src_s1 != dst_s1);
			end_s2 <= ctl_s1.valid && ctl_s1.last;
			v_s3   <= v_s2;
			end_s3 <= end_s2;
			v_s4   <= v_s3;
			end_s4 <= end_s3;
			end_s5 <= end_s4;
			res_v_q <= 1'b0;
			if (v_s4) begin
				held_v_q <= 1'b1;
				res_v_q  <= held_v_q;
			end else if (end_s5) begin
				held_v_q <= 1'b0;
				res_v_q  <= held_v_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_s2 <= ctl_s1.pos;
		for (int c = 0; c < 3; c++) begin
			ps_s2[c] <= 16'(src_s1[8*c +: 8]) * 16'(tk);
			pd_s2[c] <= 16'(dst_s1[8*c +: 8]) * 16'(k);
		end
		pos_s3 <= pos_s2;
		for (int c = 0; c < 3; c++) begin
			sum_s3[c] <= 16'(17'(ps_s2[c]) + 17'(pd_s2[c]));
		end
		pos_s4 <= pos_s3;
		for (int c = 0; c < 3; c++) begin
			q_s4[c] <= prod[c][RECIP_SHIFT +: 8] & CHANNEL_MASK;
		end
		// a new pixel pushes the held one out, the scan end flushes it as last
		if (v_s4) begin
			held_pos_q <= pos_s4;
			held_col_q <= {q_s4[2], q_s4[1], q_s4[0]};
		end
		res_q.out_z         <= held_pos_q[5:4];
		res_q.out_x         <= held_pos_q[3:2];
		res_q.out_y         <= held_pos_q[1:0];
		res_q.blended_color <= held_col_q;
		res_q.last_update   <= !v_s4;
	end

	assign result       = res_q;
	assign result_valid = res_v_q;
	assign stat.done    = end_s5;

endmodule

`default_nettype wire

>>> tb/crossfade_checker.sv
// ----------------------------------------------------------------------------
// crossfade_checker
// watches the command, configuration and result channels of the led cube
// crossfade buffer, predicts every pixel update and compares it field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crossfade_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  lccfb_pkg::in_item_t  item,
	input  logic                 cfg_we,
	input  logic [7:0]           cfg_wdata,
	input  lccfb_pkg::out_item_t result,
	input  logic                 result_valid,
	output int                   mismatches,
	output int                   updates_checked,
	output int                   pending
);
	import lccfb_pkg::*;

	// predicted frames and crossfade length
	logic [23:0] src_px [64];
	logic [23:0] dst_px [64];
	logic [7:0]  fade_len;

	// pixel updates still owed by the block, oldest first
	out_item_t fade_updates [$];

	task automatic check_field(input string name, input logic [23:0] want_v,
			input logic [23:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		int          t;
		int          k;
		int          n_diff;
		int          n_out;
		int          c;
		logic [23:0] s;
		logic [23:0] d;
		logic [23:0] mix;
		out_item_t   upd;
		out_item_t   want;
		if (!arst_n) begin
			for (int i = 0; i < 64; i++) begin
				src_px[i] = '0;
				dst_px[i] = '0;
			end
			fade_len = RESET_TICKS;
			fade_updates.delete();
			mismatches = 0;
			updates_checked = 0;
			pending <= 0;
		end else begin
			// results first: they belong to draws accepted earlier
			if (result_valid) begin
				if (fade_updates.size() == 0) begin
					$display("%0t: unexpected update, expected none, actual %0h",
						$time, result);
					mismatches++;
				end else begin
					want = fade_updates.pop_front();
					check_field("out_z", want.out_z, result.out_z);
					check_field("out_x", want.out_x, result.out_x);
					check_field("out_y", want.out_y, result.out_y);
					check_field("blended_color", want.blended_color, result.blended_color);
					check_field("last_update", want.last_update, result.last_update);
					updates_checked++;
				end
			end
			if (cfg_we)
				fade_len = cfg_wdata;
			if (start && !busy) begin
				case (item.command)
					CMD_SET_PIXEL: dst_px[{item.pos_z, item.pos_x, item.pos_y}] = item.pixel_color;
					CMD_LATCH: begin
						for (int i = 0; i < 64; i++)
							src_px[i] = dst_px[i];
					end
					CMD_DRAW: begin
						// zero length behaves as one, phase saturates at the length
						t = (fade_len == 8'd0) ? 1 : int'(fade_len);
						k = int'(item.tick) + 1;
						if (k > t)
							k = t;
						n_diff = 0;
						for (int i = 0; i < 64; i++)
							if (src_px[i] != dst_px[i])
								n_diff++;
						n_out = 0;
						for (int i = 0; i < 64; i++) begin
							s = src_px[i];
							d = dst_px[i];
							if (s != d) begin
								for (c = 0; c < 3; c++)
									mix[8*c +: 8] = 8'((int'(s[8*c +: 8]) * (t - k)
										+ int'(d[8*c +: 8]) * k) / t);
								n_out++;
								upd.out_z = 2'(i >> 4);
								upd.out_x = 2'(i >> 2);
								upd.out_y = 2'(i);
								upd.blended_color = mix;
								upd.last_update = (n_out == n_diff);
								fade_updates.push_back(upd);
							end
						end
					end
					default: ;
				endcase
			end
			pending <= fade_updates.size();
		end
	end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives set pixel, latch and draw commands into the led cube crossfade buffer
// over several crossfade lengths; a checker beside the block predicts updates
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import lccfb_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// cycles to let pass after the last update before touching the register
	localparam int SETTLE_CYCLES = 12;
	localparam int CYCLE_LIMIT = 400000;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_item_t  item;
	logic      cfg_we;
	logic [7:0] cfg_wdata;
	out_item_t result;
	logic      result_valid;

	int mismatches;
	int updates_checked;
	int pending;

	int   cycles = 0;
	int   items_sent = 0;
	int   draws_sent = 0;
	bit   burst = 1'b0;
	logic [7:0] cur_len = RESET_TICKS;

	led_cube_crossfade_buffer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result       (result),
		.result_valid (result_valid)
	);

	crossfade_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.item            (item),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.result          (result),
		.result_valid    (result_valid),
		.mismatches      (mismatches),
		.updates_checked (updates_checked),
		.pending         (pending)
	);

	always #10 clk = ~clk;

	// hard stop in case the block hangs or drops updates
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d updates still owed", cycles, pending);
			$display("tb_top failed");
			$finish;
		end
	end

	// unused fields get random content so every input bit toggles
	function automatic in_item_t pixel_write(input logic [1:0] z, input logic [1:0] x,
			input logic [1:0] y, input logic [23:0] color);
		in_item_t it;
		it.command = CMD_SET_PIXEL;
		it.pos_z = z;
		it.pos_x = x;
		it.pos_y = y;
		it.pixel_color = color;
		it.tick = 8'($urandom);
		return it;
	endfunction

	function automatic in_item_t draw_at(input logic [7:0] tick);
		in_item_t it;
		it = in_item_t'($urandom);
		it.pixel_color = 24'($urandom);
		it.command = CMD_DRAW;
		it.tick = tick;
		return it;
	endfunction

	function automatic in_item_t latch_cmd();
		in_item_t it;
		it = in_item_t'($urandom);
		it.pixel_color = 24'($urandom);
		it.command = CMD_LATCH;
		return it;
	endfunction

	// colors lean on the channel extremes
	function automatic logic [23:0] pick_color();
		case ($urandom_range(0, 7))
			0: return 24'h000000;
			1: return 24'hFFFFFF;
			default: return 24'($urandom);
		endcase
	endfunction

	// ticks around the start, the end of the fade and beyond it
	function automatic logic [7:0] pick_tick();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return cur_len - 8'd1;
			2: return cur_len;
			3: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// one command transfer, then a random idle gap on the command side
	task automatic issue(input in_item_t cmd);
		int roll;
		int gap;
		start <= 1'b1;
		item  <= cmd;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (cmd.command != CMD_UNUSED)
			items_sent++;
		if (cmd.command == CMD_DRAW)
			draws_sent++;
		roll = $urandom_range(0, 99);
		if (burst || roll < 45)
			gap = 0;
		else if (roll < 85)
			gap = $urandom_range(1, 3);
		else if (roll < 96)
			gap = $urandom_range(4, 12);
		else
			gap = $urandom_range(20, 60);
		// start stays high across back-to-back transfers
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// wait for every owed update, then for the scan or divider to wind down
	task automatic wait_settled();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_fade(input logic [7:0] len);
		wait_settled();
		cfg_we    <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_len = len;
	endtask

	initial begin
		in_item_t   junk;
		logic [7:0] len;
		int         phase_start;
		int         n;
		clk       = 1'b0;
		arst_n    = 1'b0;
		start     = 1'b0;
		item      = '0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed part at the reset length of 16
		// both frames start cleared, so nothing differs yet
		issue(draw_at(8'd0));
		issue(pixel_write(2'd0, 2'd0, 2'd0, 24'hFFFFFF));
		issue(pixel_write(2'd3, 2'd3, 2'd3, 24'h800001));
		issue(pixel_write(2'd2, 2'd1, 2'd0, 24'h00FF00));
		issue(draw_at(8'd0));
		issue(draw_at(8'd7));
		issue(draw_at(8'd14));
		// phase reaches the full length: target color comes out
		issue(draw_at(8'd15));
		issue(draw_at(8'd255));
		// unused command must leave both frames alone
		junk = in_item_t'($urandom);
		junk.pixel_color = 24'($urandom);
		junk.command = CMD_UNUSED;
		issue(junk);
		issue(draw_at(8'd0));
		issue(latch_cmd());
		// frames equal after the latch, no updates
		issue(draw_at(8'd3));
		issue(pixel_write(2'd0, 2'd0, 2'd0, 24'h000000));
		issue(pixel_write(2'd1, 2'd3, 2'd2, 24'hFFFFFF));
		issue(draw_at(8'd0));
		issue(draw_at(8'd8));
		// back to the source color at one pixel
		issue(pixel_write(2'd0, 2'd0, 2'd0, 24'hFFFFFF));
		issue(draw_at(8'd200));
		issue(latch_cmd());
		issue(draw_at(8'd0));

		// random part, one crossfade length per phase
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: len = 8'd1;
				1: len = 8'd255;
				2: len = 8'd0;
				3: len = 8'($urandom_range(2, 254));
				4: len = RESET_TICKS;
				default: len = 8'($urandom_range(1, 255));
			endcase
			program_fade(len);
			// whole new frame once, so scans emit every pixel
			if (ph == 1) begin
				burst = 1'b1;
				issue(latch_cmd());
				for (int i = 0; i < 64; i++)
					issue(pixel_write(2'(i >> 4), 2'(i >> 2), 2'(i), 24'($urandom)));
				burst = 1'b0;
				issue(draw_at(pick_tick()));
				issue(draw_at(pick_tick()));
			end
			phase_start = items_sent;
			while (items_sent - phase_start < 28) begin
				burst = ($urandom_range(0, 3) == 0);
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: begin
						// a few target writes, then draws along the fade
						n = $urandom_range(1, 6);
						repeat (n)
							issue(pixel_write(2'($urandom), 2'($urandom), 2'($urandom),
								pick_color()));
						n = $urandom_range(1, 3);
						repeat (n) issue(draw_at(pick_tick()));
					end
					5: begin
						issue(latch_cmd());
						issue(draw_at(pick_tick()));
					end
					6: begin
						issue(pixel_write(2'($urandom), 2'($urandom), 2'($urandom),
							pick_color()));
						issue(latch_cmd());
						issue(pixel_write(2'($urandom), 2'($urandom), 2'($urandom),
							pick_color()));
						issue(draw_at(pick_tick()));
					end
					7, 8: issue(draw_at(pick_tick()));
					default: begin
						// noise: any command code with random fields
						n = $urandom_range(1, 3);
						repeat (n) begin
							junk = in_item_t'($urandom);
							junk.pixel_color = 24'($urandom);
							junk.command = 2'($urandom);
							issue(junk);
						end
					end
				endcase
			end
		end

		wait_settled();
		$display("covered %0d commands including %0d draws, %0d pixel updates compared",
			items_sent, draws_sent, updates_checked);
		$display("crossfade lengths: reset value, 1, 255, 0, 16 and two random lengths");
		if (mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+design
design/lccfb_pkg.sv
design/lccfb_frames.sv
design/lccfb_recip.sv
design/lccfb_blend.sv
design/led_cube_crossfade_buffer.sv
tb/crossfade_checker.sv
tb/tb_top.sv
